// ----- sv/rmap_pkg.sv -----
// ============================================================================
// rmap_pkg
// Types, status codes and the build-time register descriptor table of the
// I2C register map slave.
// ============================================================================
package rmap_pkg;

    // result status codes
    localparam logic [1:0] STATUS_ACCESS  = 2'd0;
    localparam logic [1:0] STATUS_POINTER = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;
    localparam logic [1:0] STATUS_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_IGNORE_MASK   = 2'd0;
    localparam logic [1:0] CFG_IDX_MSB_FIRST     = 2'd1;
    localparam logic [1:0] CFG_IDX_DEFAULT_WIDTH = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // descriptor table
    localparam int MAP_ENTRIES = 6;
    localparam int SLOT_W      = $clog2(MAP_ENTRIES);

    localparam logic [7:0] TBL_ADDR [MAP_ENTRIES] =
        '{8'h00, 8'h01, 8'h02, 8'h10, 8'h20, 8'h30};
    localparam logic [2:0] TBL_WIDTH [MAP_ENTRIES] =
        '{3'd1, 3'd1, 3'd1, 3'd2, 3'd4, 3'd0};
    localparam logic TBL_RO [MAP_ENTRIES] =
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam logic [31:0] TBL_RESET [MAP_ENTRIES] =
        '{32'h0000_005A, 32'h0000_0000, 32'h0000_0001,
          32'h0000_1234, 32'h0000_0000, 32'h0000_0000};
    localparam logic [31:0] TBL_WMASK [MAP_ENTRIES] =
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          32'h0000_0000, 32'h00FF_FFFF, 32'h0000_0000};
    localparam logic [31:0] TBL_COR [MAP_ENTRIES] =
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
          32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    localparam logic [31:0] TBL_SC [MAP_ENTRIES] =
        '{32'h0000_0000, 32'h0000_0080, 32'h0000_0000,
          32'h0000_0000, 32'h0000_0000, 32'h0000_0000};

    typedef struct packed {
        logic       mode;
        logic [7:0] write_byte;
        logic       transfer_start;
        logic       message_start;
        logic       restart;
        logic       stop;
    } t_in;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic [7:0] address_ignore_mask;
        logic       msb_first;
        logic [2:0] default_width_bytes;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_hit;

    // descriptor lookup by register address
    function automatic t_hit slot_of(input logic [7:0] addr);
        t_hit r;
        r.hit  = 1'b0;
        r.slot = '0;
        for (int i = 0; i < MAP_ENTRIES; i++) begin
            if (TBL_ADDR[i] == addr) begin
                r.hit  = 1'b1;
                r.slot = SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/rmap_engine.sv -----
// ============================================================================
// rmap_engine
// Register file state and the per-byte access logic: pointer set, byte
// read/write with auto-increment, error and ignore handling.
// ============================================================================
module rmap_engine #(
    parameter int ADDRESS_COUNT   = 256,
    parameter int MAX_WIDTH_BYTES = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  rmap_pkg::t_in  i_item,
    input  rmap_pkg::t_cfg i_cfg,
    output rmap_pkg::t_out o_result
);

    localparam logic [8:0] ADDR_LIMIT = 9'(ADDRESS_COUNT);
    localparam logic [2:0] MAXW       = 3'(MAX_WIDTH_BYTES);

    logic [8:0]  r_ptr,       n_ptr;
    logic [1:0]  r_bpos,      n_bpos;
    logic [31:0] r_pend,      n_pend;
    logic [7:0]  r_pend_addr, n_pend_addr;
    logic        r_pend_vld,  n_pend_vld;
    logic        r_wcont,     n_wcont;
    logic        r_failed,    n_failed;
    logic [31:0] r_val [rmap_pkg::MAP_ENTRIES];

    logic        n_val_we;
    logic [31:0] n_val;

    rmap_pkg::t_hit           lk;
    logic [rmap_pkg::SLOT_W-1:0] slot;
    logic        ms, failed_eff, wcont_prev, pend_vld_eff, is_ptr, addr_ok;
    logic [2:0]  w_raw, w_sel, w_eff;
    logic        off_bad, last;
    logic [1:0]  sh_idx;
    logic [4:0]  sh;
    logic [31:0] old, pend_base, bmask, wmask, wbits;

    assign lk   = rmap_pkg::slot_of(r_ptr[7:0]);
    assign slot = lk.slot;

    always_comb begin
        ms           = i_item.transfer_start | i_item.message_start;
        failed_eff   = r_failed & ~i_item.transfer_start;
        wcont_prev   = r_wcont & ~i_item.transfer_start;
        pend_vld_eff = r_pend_vld & ~i_item.transfer_start;
        is_ptr       = ms & ~i_item.mode & (~wcont_prev | i_item.restart);
        addr_ok      = ~r_ptr[8] & (r_ptr < ADDR_LIMIT) & lk.hit;

        // effective register width, 1..MAX_WIDTH_BYTES
        w_raw = rmap_pkg::TBL_WIDTH[slot];
        w_sel = (w_raw == 3'd0) ? i_cfg.default_width_bytes : w_raw;
        if (w_sel == 3'd0) begin
            w_sel = 3'd1;
        end
        w_eff = (w_sel > MAXW) ? MAXW : w_sel;

        off_bad = ({1'b0, r_bpos} >= w_eff);
        last    = (({1'b0, r_bpos} + 3'd1) == w_eff);
        sh_idx  = i_cfg.msb_first ? 2'(w_eff - {1'b0, r_bpos} - 3'd1) : r_bpos;
        sh      = {sh_idx, 3'b000};

        old       = r_val[slot];
        pend_base = ((r_bpos == 2'd0) || !pend_vld_eff || (r_pend_addr != r_ptr[7:0]))
                    ? old : r_pend;
        bmask     = 32'h0000_00FF << sh;
        if (rmap_pkg::TBL_RO[slot]) begin
            wmask = '0;
        end else if (rmap_pkg::TBL_WMASK[slot] != '0) begin
            wmask = bmask & rmap_pkg::TBL_WMASK[slot];
        end else begin
            wmask = bmask;
        end
        wbits = (32'(i_item.write_byte) << sh) & wmask;

        // defaults: state holds, transfer start clears its flags
        n_ptr       = r_ptr;
        n_bpos      = r_bpos;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_pend_vld  = pend_vld_eff;
        n_wcont     = wcont_prev;
        n_failed    = failed_eff;
        n_val_we    = 1'b0;
        n_val       = old;
        o_result.read_byte = 8'h00;
        o_result.status    = rmap_pkg::STATUS_ACCESS;

        if (failed_eff) begin
            o_result.status = rmap_pkg::STATUS_IGNORED;
        end else begin
            n_wcont = ~i_item.mode & ~i_item.stop;
            if (is_ptr) begin
                n_ptr           = {1'b0, i_item.write_byte & ~i_cfg.address_ignore_mask};
                n_bpos          = 2'd0;
                o_result.status = rmap_pkg::STATUS_POINTER;
            end else if (!addr_ok || off_bad) begin
                n_failed        = 1'b1;
                o_result.status = rmap_pkg::STATUS_ERROR;
            end else begin
                n_pend_addr = r_ptr[7:0];
                n_pend_vld  = 1'b1;
                if (i_item.mode) begin
                    n_pend             = pend_base;
                    o_result.read_byte = 8'(old >> sh);
                    n_val              = old & ~rmap_pkg::TBL_COR[slot];
                end else begin
                    n_pend = (pend_base & ~wmask) | wbits;
                    n_val  = n_pend & ~rmap_pkg::TBL_SC[slot];
                end
                n_val_we = last;
                if (last) begin
                    n_bpos = 2'd0;
                    n_ptr  = r_ptr + 9'd1;
                end else begin
                    n_bpos = r_bpos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_bpos     <= '0;
            r_pend     <= '0;
            r_pend_vld <= 1'b0;
            r_wcont    <= 1'b0;
            r_failed   <= 1'b0;
            for (int i = 0; i < rmap_pkg::MAP_ENTRIES; i++) begin
                r_val[i] <= rmap_pkg::TBL_RESET[i];
            end
        end else if (i_fire) begin
            r_ptr      <= n_ptr;
            r_bpos     <= n_bpos;
            r_pend     <= n_pend;
            r_pend_vld <= n_pend_vld;
            r_wcont    <= n_wcont;
            r_failed   <= n_failed;
            if (n_val_we) begin
                r_val[slot] <= n_val;
            end
        end
    end

    // qualified by r_pend_vld, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_pend_addr <= n_pend_addr;
        end
    end

endmodule

// ----- sv/i2c_register_map_slave_core.sv -----
// ============================================================================
// i2c_register_map_slave_core
// Register file behind an I2C target, one bus byte event per transaction.
// Data path: the input register takes the byte at the accepting edge, the
//   result register takes its result when the byte moves on.
// Throughput: one transaction per cycle; a held result stalls the input only
//   once the input register is full as well.
// Reset (synchronous, active low): pointer, flags and pipeline valids clear,
//   registers take their descriptor reset values, configuration its defaults.
// ============================================================================
module i2c_register_map_slave_core #(
    parameter int ADDRESS_COUNT   = 256,
    parameter int MAX_WIDTH_BYTES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rmap_pkg::t_in                     i_in,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rmap_pkg::t_out                    o_out,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [rmap_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rmap_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic           r_in_valid;
    rmap_pkg::t_in  r_in;
    logic           r_out_valid;
    rmap_pkg::t_out r_out;
    rmap_pkg::t_cfg r_cfg;
    rmap_pkg::t_out result;

    logic in_accept;
    logic move;      // input register advances into the result register

    // The result register parts the two sides: the held item moves whenever
    // the result slot is empty or being drained this cycle.
    assign move       = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~move;
    assign in_accept  = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    // State update and result are produced in the same cycle the byte moves.
    rmap_engine #(
        .ADDRESS_COUNT   (ADDRESS_COUNT),
        .MAX_WIDTH_BYTES (MAX_WIDTH_BYTES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (move),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= result;
        end
    end

    // Configuration registers; writes to an unlisted index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_ignore_mask <= 8'h00;
            r_cfg.msb_first           <= 1'b0;
            r_cfg.default_width_bytes <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rmap_pkg::CFG_IDX_IGNORE_MASK: begin
                    r_cfg.address_ignore_mask <= i_cfg_wdata;
                end
                rmap_pkg::CFG_IDX_MSB_FIRST: begin
                    r_cfg.msb_first <= i_cfg_wdata[0];
                end
                rmap_pkg::CFG_IDX_DEFAULT_WIDTH: begin
                    r_cfg.default_width_bytes <= i_cfg_wdata[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- sv/rmap_checker.sv -----
// ============================================================================
// rmap_checker
// Port-level checks of the register map slave, bound to the top level.
// ============================================================================
module rmap_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input rmap_pkg::t_out                   o_out
);

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // only a byte access carries read data
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != rmap_pkg::STATUS_ACCESS) |-> o_out.read_byte == 8'h00)
        else $error("read data on a non-access result");

    // input back-pressure only while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind i2c_register_map_slave_core rmap_checker u_rmap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ----- tb/tb_i2c_register_map_slave_core.sv -----
// ============================================================================
// tb_i2c_register_map_slave_core
// Self-checking bench for the I2C register map slave core. Byte events go in
// on the valid/stall input channel. A scoreboard keeps its own register file,
// pointer and transfer flags. It works out the status and read byte of every
// accepted event and compares them, in order, with the replies on the result
// channel. A short directed sequence comes first. Then come phases of random
// transfers, most of them well formed, under several address-mask,
// endianness and default-width settings.
// ============================================================================
module tb_i2c_register_map_slave_core;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Scoreboard: a mirror of the register file and access state, plus the
    // queue of replies still owed by the block
    // ------------------------------------------------------------------------
    class byte_event_scoreboard;
        localparam int MAP_SIZE  = 256;
        localparam int WIDTH_CAP = 4;

        // configuration
        logic [7:0]  ignore_mask;
        bit          msb_first;
        logic [2:0]  default_bytes;

        // register file and descriptors
        logic [31:0] reg_value [MAP_SIZE];
        bit          reg_present [MAP_SIZE];
        logic [2:0]  reg_width [MAP_SIZE];
        bit          reg_read_only [MAP_SIZE];
        logic [31:0] reg_wmask [MAP_SIZE];
        logic [31:0] reg_cor [MAP_SIZE];
        logic [31:0] reg_sc [MAP_SIZE];

        // access state
        logic [8:0]  reg_pointer;
        int          byte_pos;
        logic [31:0] staged_word;
        logic [8:0]  staged_addr;
        bit          staged_ok;
        bit          writing_on;
        bit          failed;

        rmap_pkg::t_out expected_replies [$];
        int             mismatches;

        function new();
            int a;
            ignore_mask   = '0;
            msb_first     = 1'b0;
            default_bytes = 3'd1;
            for (int i = 0; i < MAP_SIZE; i++) begin
                reg_value[i]     = '0;
                reg_present[i]   = 1'b0;
                reg_width[i]     = '0;
                reg_read_only[i] = 1'b0;
                reg_wmask[i]     = '0;
                reg_cor[i]       = '0;
                reg_sc[i]        = '0;
            end
            for (int i = 0; i < rmap_pkg::MAP_ENTRIES; i++) begin
                a = rmap_pkg::TBL_ADDR[i];
                reg_value[a]     = rmap_pkg::TBL_RESET[i];
                reg_present[a]   = 1'b1;
                reg_width[a]     = rmap_pkg::TBL_WIDTH[i];
                reg_read_only[a] = rmap_pkg::TBL_RO[i];
                reg_wmask[a]     = rmap_pkg::TBL_WMASK[i];
                reg_cor[a]       = rmap_pkg::TBL_COR[i];
                reg_sc[a]        = rmap_pkg::TBL_SC[i];
            end
            reg_pointer = '0;
            byte_pos    = 0;
            staged_word = '0;
            staged_addr = '0;
            staged_ok   = 1'b0;
            writing_on  = 1'b0;
            failed      = 1'b0;
            mismatches  = 0;
        endfunction

        function void apply_setting(logic [rmap_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] data);
            case (idx)
                rmap_pkg::CFG_IDX_IGNORE_MASK:   ignore_mask   = data;
                rmap_pkg::CFG_IDX_MSB_FIRST:     msb_first     = data[0];
                rmap_pkg::CFG_IDX_DEFAULT_WIDTH: default_bytes = data[2:0];
                default: ;
            endcase
        endfunction

        // one bus byte event: returns the reply and advances the mirror
        function rmap_pkg::t_out predict_byte_event(rmap_pkg::t_in ev);
            rmap_pkg::t_out r;
            bit          msg_open, was_writing;
            logic [8:0]  adr;
            int          w, off, sh;
            logic [31:0] old, lane;
            r.read_byte = '0;
            r.status    = rmap_pkg::STATUS_ACCESS;
            msg_open    = ev.transfer_start | ev.message_start;
            if (ev.transfer_start) begin
                writing_on = 1'b0;
                staged_ok  = 1'b0;
                failed     = 1'b0;
            end
            if (failed) begin
                r.status = rmap_pkg::STATUS_IGNORED;
                return r;
            end
            was_writing = writing_on;
            writing_on  = !ev.mode && !ev.stop;
            if (msg_open && !ev.mode && (!was_writing || ev.restart)) begin
                reg_pointer = {1'b0, ev.write_byte & ~ignore_mask};
                byte_pos    = 0;
                r.status    = rmap_pkg::STATUS_POINTER;
                return r;
            end
            adr = reg_pointer;
            if (adr >= MAP_SIZE || !reg_present[adr[7:0]]) begin
                failed   = 1'b1;
                r.status = rmap_pkg::STATUS_ERROR;
                return r;
            end
            w = reg_width[adr[7:0]];
            if (w == 0) w = default_bytes;
            if (w == 0) w = 1;
            if (w > WIDTH_CAP) w = WIDTH_CAP;
            off = byte_pos;
            // byte position left over from a wider default width
            if (off >= w) begin
                failed   = 1'b1;
                r.status = rmap_pkg::STATUS_ERROR;
                return r;
            end
            sh  = 8 * (msb_first ? (w - off - 1) : off);
            old = reg_value[adr[7:0]];
            if (off == 0 || !staged_ok || staged_addr != adr) begin
                staged_word = old;
                staged_addr = adr;
                staged_ok   = 1'b1;
            end
            lane = 32'hFF << sh;
            if (ev.mode) begin
                r.read_byte = 8'(old >> sh);
                if (off + 1 == w) reg_value[adr[7:0]] &= ~reg_cor[adr[7:0]];
            end else begin
                if (reg_read_only[adr[7:0]]) lane = '0;
                else if (reg_wmask[adr[7:0]] != '0) lane &= reg_wmask[adr[7:0]];
                staged_word = (staged_word & ~lane) | ((32'(ev.write_byte) << sh) & lane);
                if (off + 1 == w) reg_value[adr[7:0]] = staged_word & ~reg_sc[adr[7:0]];
            end
            off++;
            if (off == w) begin
                off         = 0;
                reg_pointer = adr + 9'd1;
            end
            byte_pos = off;
            return r;
        endfunction

        function void note_byte_event(rmap_pkg::t_in ev);
            expected_replies.push_back(predict_byte_event(ev));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch @%0t: %s", $realtime, msg);
        endtask

        task check_reply(rmap_pkg::t_out got);
            rmap_pkg::t_out want;
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("reply with none pending: byte %h status %0d",
                                          got.read_byte, got.status));
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.read_byte !== want.read_byte)
                report_mismatch($sformatf("read_byte %h, expected %h",
                                          got.read_byte, want.read_byte));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    rmap_pkg::t_in in_data = '0;
    logic out_stall = 1'b0;
    logic cfg_we    = 1'b0;
    logic [rmap_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rmap_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic           in_stall;
    logic           out_valid;
    rmap_pkg::t_out out_data;

    // when set, neither side inserts gaps or stalls
    bit calm = 1'b0;
    int sent_events = 0;

    byte_event_scoreboard board = new();

    always #4 clk = ~clk;

    i2c_register_map_slave_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // Result side: random backpressure, asserted about 6 percent of the time.
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 6);
    end

    // Every reply taken at this edge goes to the scoreboard. Values read here
    // are the pre-edge ones, which is what decided the handshake.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_reply(out_data);
    end

    // ------------------------------------------------------------------------
    // Drivers. Each task starts and ends right after a rising edge.
    // ------------------------------------------------------------------------
    function automatic rmap_pkg::t_in byte_event(bit md, logic [7:0] wb, bit ts, bit ms,
                                                 bit rs, bit sp);
        rmap_pkg::t_in e;
        e.mode           = md;
        e.write_byte     = wb;
        e.transfer_start = ts;
        e.message_start  = ms;
        e.restart        = rs;
        e.stop           = sp;
        return e;
    endfunction

    // One transaction on the input channel; valid stays up into the next
    // call unless a gap is rolled.
    task automatic send_event(rmap_pkg::t_in ev);
        if (!calm && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_byte_event(ev);
        sent_events++;
    endtask

    // Drop valid and wait until every owed reply has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_setting(logic [rmap_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.apply_setting(idx, data);
    endtask

    // A random transfer: mostly well-formed messages (pointer byte, data,
    // restarted reads, continued writes), sometimes raw noise.
    task automatic run_transfer();
        int            msgs, nbytes;
        bit            rd, rs, sp;
        logic [7:0]    wb, base;
        logic [31:0]   rnd;
        rmap_pkg::t_in ev;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 4)) begin
                rnd = $urandom;
                ev  = rnd[$bits(rmap_pkg::t_in)-1:0];
                ev.transfer_start = ($urandom_range(0, 3) == 0);
                send_event(ev);
            end
        end else begin
            msgs = $urandom_range(1, 3);
            for (int m = 0; m < msgs; m++) begin
                rd     = (m == 0) ? ($urandom_range(0, 9) == 0) : 1'($urandom_range(0, 1));
                rs     = (m > 0) && ($urandom_range(0, 3) != 0);
                sp     = (m == msgs - 1) ? ($urandom_range(0, 4) != 0)
                                         : ($urandom_range(0, 3) == 0);
                nbytes = $urandom_range(1, 6);
                for (int b = 0; b < nbytes; b++) begin
                    wb = 8'($urandom);
                    // first write byte of a message mostly aims at a mapped register,
                    // sometimes at 0x31 or a random address; the masked bits random
                    if (b == 0 && !rd) begin
                        case ($urandom_range(0, 7))
                            6:       base = 8'h31;
                            7:       base = 8'($urandom);
                            default: base = rmap_pkg::TBL_ADDR[rmap_pkg::SLOT_W'(
                                         $urandom_range(0, rmap_pkg::MAP_ENTRIES - 1))];
                        endcase
                        wb = base | (wb & board.ignore_mask);
                    end
                    send_event(byte_event(rd, wb, m == 0 && b == 0, b == 0, rs, sp));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] mask_sel;
        logic [2:0] width_sel;
        bit         order_sel;
        int         phase_goal;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // -- directed, reset settings (mask 0, little endian, width 1) --
        // pointer to 0x00
        send_event(byte_event(1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
        // restart read, read-only reg
        send_event(byte_event(1'b1, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1));
        send_event(byte_event(1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1)); // 0x01
        send_event(byte_event(1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1)); // 0x02, clear on read
        send_event(byte_event(1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1)); // 0x03 absent: error
        send_event(byte_event(1'b0, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1)); // ignored after error
        // transfer start as read: 0x03 again
        send_event(byte_event(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
        send_event(byte_event(1'b0, 8'h01, 1'b1, 1'b1, 1'b0, 1'b0)); // pointer 0x01
        send_event(byte_event(1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0)); // self-clearing bit 7
        // restarted write: new pointer
        send_event(byte_event(1'b0, 8'h01, 1'b0, 1'b1, 1'b1, 1'b0));
        send_event(byte_event(1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1)); // read back 0x01
        send_event(byte_event(1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1)); // 0x02 now cleared
        send_event(byte_event(1'b0, 8'h10, 1'b1, 1'b1, 1'b0, 1'b0)); // two-byte read-only
        send_event(byte_event(1'b0, 8'hAB, 1'b0, 1'b0, 1'b0, 1'b0)); // staged, no effect
        send_event(byte_event(1'b0, 8'h10, 1'b0, 1'b1, 1'b1, 1'b0));
        send_event(byte_event(1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0)); // low byte
        // new message, high byte
        send_event(byte_event(1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        // four-byte masked register
        send_event(byte_event(1'b0, 8'h20, 1'b1, 1'b1, 1'b0, 1'b0));
        send_event(byte_event(1'b0, 8'h11, 1'b0, 1'b0, 1'b0, 1'b0));
        // write continues, no restart
        send_event(byte_event(1'b0, 8'h22, 1'b0, 1'b1, 1'b0, 1'b0));
        // mode change within message
        send_event(byte_event(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        // last byte, top lane masked
        send_event(byte_event(1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1));
        // default-width register
        send_event(byte_event(1'b0, 8'h30, 1'b1, 1'b1, 1'b0, 1'b0));
        send_event(byte_event(1'b0, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b1));
        send_event(byte_event(1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1)); // 0x31: past the map
        drain();

        // -- random phases, each under its own settings --
        for (int ph = 1; ph <= 8; ph++) begin
            case (ph)
                1: begin mask_sel = 8'h00; order_sel = 1'b1; width_sel = 3'd4; end
                2: begin mask_sel = 8'hFF; order_sel = 1'b0; width_sel = 3'd1; end
                3: begin mask_sel = 8'h0F; order_sel = 1'b1; width_sel = 3'd2; end
                4: begin mask_sel = 8'h80; order_sel = 1'b0; width_sel = 3'd3; end
                default: begin
                    mask_sel  = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
                    order_sel = 1'($urandom_range(0, 1));
                    width_sel = 3'($urandom_range(1, 4));
                end
            endcase
            write_setting(rmap_pkg::CFG_IDX_IGNORE_MASK, mask_sel);
            write_setting(rmap_pkg::CFG_IDX_MSB_FIRST, {7'd0, order_sel});
            write_setting(rmap_pkg::CFG_IDX_DEFAULT_WIDTH, {5'd0, width_sel});
            calm = (ph == 3);

            // resume mid-register from the previous phase: may hit a byte
            // position beyond the new default width
            send_event(byte_event(1'b1, 8'($urandom), 1'b1, 1'b1, 1'b0, 1'b0));
            send_event(byte_event(1'b1, 8'($urandom), 1'b0, 1'b0, 1'b0, 1'b1));

            phase_goal = sent_events + 45;
            while (sent_events < phase_goal) run_transfer();

            // write one byte of the default-width register, left open for the next phase
            send_event(byte_event(1'b0, 8'h30, 1'b1, 1'b1, 1'b0, 1'b0));
            send_event(byte_event(1'b0, 8'($urandom), 1'b0, 1'b0, 1'b0, 1'b0));
            drain();
        end
        calm = 1'b0;

        // settle, then catch any stray replies
        repeat (10) @(posedge clk);
        if (board.expected_replies.size() != 0)
            board.report_mismatch($sformatf("%0d replies never arrived",
                                            board.expected_replies.size()));
        if (board.mismatches == 0) begin
            $display("[i2c_register_map_slave_core] OK");
        end else begin
            $display("[i2c_register_map_slave_core] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("[i2c_register_map_slave_core] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rmap_pkg.sv
sv/rmap_engine.sv
sv/i2c_register_map_slave_core.sv
sv/rmap_checker.sv
tb/tb_i2c_register_map_slave_core.sv
